// File: rtl/cabn_pkg.sv
// ============================================================================
// Box suppression package
// Shared widths, types and the reset threshold.
// ============================================================================
package cabn_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = IDX_W + 1;
    localparam logic [15:0] THRESH_RESET = 16'd29491;

    typedef struct packed {
        logic [15:0]        score;
        logic signed [11:0] left;
        logic signed [11:0] top;
        logic [10:0]        width;
        logic [10:0]        height;
    } box_t;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_RANK  = 7'b0000010,
        ST_RWAIT = 7'b0000100,
        ST_PAIR  = 7'b0001000,
        ST_PWAIT = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_EWAIT = 7'b1000000
    } state_t;

endpackage

// File: rtl/class_agnostic_box_nms.sv
// ============================================================================
// Class-agnostic box suppression
// Greedy non-maximum suppression over one set of up to 64 boxes.
// ============================================================================
// Boxes load one per cycle while busy is low; the beat with last_box high
// closes the set and raises busy. Ranking reads every ordered pair of boxes
// from the box memory. The pairwise pass tests each pair of ranked boxes in
// which neither box is suppressed and skips the rest; emission reads back
// each kept box and skips the suppressed ones. Results appear one per
// strobe; the receiver cannot stall them.
module class_agnostic_box_nms
    import cabn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        score,
    input  logic signed [11:0] left,
    input  logic signed [11:0] top,
    input  logic [10:0]        width,
    input  logic [10:0]        height,
    input  logic               last_box,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    output logic               result_valid,
    output logic [5:0]         box_index,
    output logic [15:0]        kept_score,
    output logic signed [11:0] kept_left,
    output logic signed [11:0] kept_top,
    output logic [10:0]        kept_width,
    output logic [10:0]        kept_height,
    output logic               final_result,
    output logic               overflow
);

    // Box memory (arrival order) and rank memory (rank -> arrival index).
    box_t             box_mem [MAX_BOXES];
    logic [IDX_W-1:0] rank_mem [MAX_BOXES];
    box_t             rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0] rank_rd_reg;

    state_t           state_reg, state_next;
    logic [15:0]      thr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [MAX_BOXES-1:0] sup_reg, sup_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [15:0]      isc_reg, isc_next;
    logic             iou_go, iou_done, iou_hit;
    logic             accept;
    logic [CNT_W-1:0] last_kept;
    logic             res_v_reg, res_v_next;
    logic [5:0]       res_idx_reg, res_idx_next;
    box_t             res_box_reg, res_box_next;
    logic             res_fin_reg, res_fin_next;
    logic             res_ovf_reg, res_ovf_next;
    logic             rank_we;
    logic [IDX_W-1:0] rank_wa, rank_wd;
    logic [IDX_W-1:0] box_ra, box_rb, rank_ra;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_LOAD);
    assign cfg_ready = (state_reg == ST_LOAD);

    // Lowest-ranked (last) unsuppressed position among the counted boxes.
    always_comb
    begin
        last_kept = '0;
        for (int k = 0; k < MAX_BOXES; k++)
            if (CNT_W'(k) < count_reg && !sup_reg[k])
                last_kept = CNT_W'(k);
    end

    cabn_iou u_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iou_go),
        .box_a     (rd_a_reg),
        .box_b     (rd_b_reg),
        .threshold (thr_reg),
        .out_valid (iou_done),
        .exceeds   (iou_hit)
    );

    // Control. Ranking: for box i, its rank is the number of boxes j with a
    // higher score or equal score and earlier arrival; j sweeps the set.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        sup_next     = sup_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pos_next     = pos_reg;
        isc_next     = isc_reg;
        iou_go       = 1'b0;
        rank_we      = 1'b0;
        rank_wa      = pos_reg[IDX_W-1:0];
        rank_wd      = i_reg[IDX_W-1:0];
        box_ra       = i_reg[IDX_W-1:0];
        box_rb       = j_reg[IDX_W-1:0];
        rank_ra      = i_reg[IDX_W-1:0];
        res_v_next   = 1'b0;
        res_idx_next = res_idx_reg;
        res_box_next = res_box_reg;
        res_fin_next = res_fin_reg;
        res_ovf_next = res_ovf_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_BOXES))
                        count_next = count_reg + 1'b1;
                    else
                        ovf_next = 1'b1;
                    if (last_box)
                    begin
                        state_next = ST_RWAIT;
                        i_next     = '0;
                        j_next     = '0;
                        pos_next   = '0;
                    end
                end
            end
            ST_RWAIT:
            begin
                // Reads of box i and box j are presented; data next cycle.
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                if (rd_b_reg.score > rd_a_reg.score ||
                    (rd_b_reg.score == rd_a_reg.score && j_reg < i_reg))
                    pos_next = pos_reg + 1'b1;
                if (j_reg + 1'b1 == count_reg)
                begin
                    rank_we = 1'b1;
                    rank_wa = pos_next[IDX_W-1:0];
                    j_next  = '0;
                    pos_next = '0;
                    if (i_reg + 1'b1 == count_reg)
                    begin
                        i_next     = '0;
                        j_next     = CNT_W'(1);
                        state_next = ST_PWAIT;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_RWAIT;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_RWAIT;
                end
            end
            ST_PWAIT:
            begin
                // Pair loop: i over ranks, j over later ranks.
                if (i_reg + 1'b1 >= count_reg)
                begin
                    i_next     = '0;
                    state_next = ST_EWAIT;
                end
                else if (sup_reg[i_reg[IDX_W-1:0]] || j_reg >= count_reg)
                begin
                    i_next = i_reg + 1'b1;
                    j_next = i_reg + 2'd2;
                end
                else if (sup_reg[j_reg[IDX_W-1:0]])
                    j_next = j_reg + 1'b1;
                else
                begin
                    pos_next   = '0;
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                // pos counts phases: rank reads, box reads, test launch, wait.
                pos_next = pos_reg + 1'b1;
                rank_ra  = (pos_reg == '0) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
                if (pos_reg == CNT_W'(1))
                    isc_next = {10'd0, rank_rd_reg};
                if (pos_reg == CNT_W'(2))
                begin
                    box_ra = isc_reg[IDX_W-1:0];
                    box_rb = rank_rd_reg;
                end
                if (pos_reg == CNT_W'(3))
                    iou_go = 1'b1;
                if (iou_done)
                begin
                    if (iou_hit)
                        sup_next[j_reg[IDX_W-1:0]] = 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = ST_PWAIT;
                end
            end
            ST_EWAIT:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = ST_LOAD;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    sup_next   = '0;
                end
                else if (sup_reg[i_reg[IDX_W-1:0]])
                    i_next = i_reg + 1'b1;
                else
                begin
                    pos_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                pos_next = pos_reg + 1'b1;
                box_ra   = rank_rd_reg;
                if (pos_reg == CNT_W'(2))
                begin
                    res_v_next   = 1'b1;
                    res_idx_next = 6'(isc_reg);
                    res_box_next = rd_a_reg;
                    res_fin_next = (i_reg == last_kept);
                    res_ovf_next = ovf_reg;
                    i_next       = i_reg + 1'b1;
                    state_next   = ST_EWAIT;
                end
                if (pos_reg == CNT_W'(1))
                    isc_next = {10'd0, rank_rd_reg};
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Memories: box writes on accepted beats while there is room, rank writes during ranking.
    always_ff @(posedge clk)
    begin
        if (accept && count_reg < CNT_W'(MAX_BOXES))
            box_mem[count_reg[IDX_W-1:0]] <= '{score, left, top, width, height};
        if (rank_we)
            rank_mem[rank_wa] <= rank_wd;
        rd_a_reg    <= box_mem[box_ra];
        rd_b_reg    <= box_mem[box_rb];
        rank_rd_reg <= rank_mem[rank_ra];
        isc_reg     <= isc_next;
        res_idx_reg <= res_idx_next;
        res_box_reg <= res_box_next;
        res_fin_reg <= res_fin_next;
        res_ovf_reg <= res_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            thr_reg   <= THRESH_RESET;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sup_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            pos_reg   <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            sup_reg   <= sup_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pos_reg   <= pos_next;
            res_v_reg <= res_v_next;
        end
    end

    assign result_valid = res_v_reg;
    assign box_index    = res_idx_reg;
    assign kept_score   = res_box_reg.score;
    assign kept_left    = res_box_reg.left;
    assign kept_top     = res_box_reg.top;
    assign kept_width   = res_box_reg.width;
    assign kept_height  = res_box_reg.height;
    assign final_result = res_fin_reg;
    assign overflow     = res_ovf_reg;

    // A result only leaves while the set is being emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result outside emission");

    // The box count never exceeds capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count over capacity");

    // Closing beat always leaves the load state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_box) |=> busy)
        else $error("set close did not start processing");

endmodule

// File: rtl/cabn_iou.sv
// ============================================================================
// Overlap test unit
// Two-stage test: intersection*65536 > threshold*union.
// ============================================================================
module cabn_iou
    import cabn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  box_t        box_a,
    input  box_t        box_b,
    input  logic [15:0] threshold,
    output logic        out_valid,
    output logic        exceeds
);

    logic signed [12:0] ax2, bx2, ay2, by2, x1, y1, x2, y2;
    logic [11:0]        iw, ih;
    logic [23:0]        inter_next, inter_reg;
    logic [21:0]        area_a_next, area_a_reg, area_b_next, area_b_reg;
    logic               v1_reg, v2_reg;
    logic [22:0]        uni;
    logic [39:0]        lhs_next, lhs_reg;
    logic [38:0]        rhs_next, rhs_reg;

    // Stage one: intersection and the two areas.
    always_comb
    begin
        ax2 = 13'(box_a.left) + 13'(signed'({1'b0, box_a.width}));
        bx2 = 13'(box_b.left) + 13'(signed'({1'b0, box_b.width}));
        ay2 = 13'(box_a.top) + 13'(signed'({1'b0, box_a.height}));
        by2 = 13'(box_b.top) + 13'(signed'({1'b0, box_b.height}));
        x1 = (box_a.left > box_b.left) ? 13'(box_a.left) : 13'(box_b.left);
        y1 = (box_a.top > box_b.top) ? 13'(box_a.top) : 13'(box_b.top);
        x2 = (ax2 < bx2) ? ax2 : bx2;
        y2 = (ay2 < by2) ? ay2 : by2;
        iw = (x2 > x1) ? 12'(x2 - x1) : 12'd0;
        ih = (y2 > y1) ? 12'(y2 - y1) : 12'd0;
        inter_next  = iw * ih;
        area_a_next = box_a.width * box_a.height;
        area_b_next = box_b.width * box_b.height;
    end

    // Stage two: scaled compare terms.
    always_comb
    begin
        uni      = 23'(area_a_reg) + 23'(area_b_reg) - 23'(inter_reg);
        lhs_next = {inter_reg, 16'd0};
        rhs_next = threshold * uni;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        inter_reg  <= inter_next;
        area_a_reg <= area_a_next;
        area_b_reg <= area_b_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
    end

    assign out_valid = v2_reg;
    assign exceeds   = lhs_reg > 40'(rhs_reg);

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box suppression testbench
// Sends box sets through the box input port, predicts the kept boxes with a
// local greedy suppression model and checks every result strobe against it.
// The threshold register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top
    import cabn_pkg::*;
;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 60;

    // One kept box as the block reports it.
    typedef struct {
        logic [5:0] idx;
        box_t       bx;
        logic       fin;
        logic       ovf;
    } kept_t;

    // Scoreboard: collects one set of boxes, ranks and suppresses it on the
    // closing beat, and queues the kept boxes in rank order.
    class nms_scoreboard;
        box_t        set_boxes[$];
        logic        set_dropped;
        logic [15:0] thresh;
        kept_t       kept_q[$];
        int          mismatches;

        function new();
            thresh      = THRESH_RESET;
            set_dropped = 0;
            mismatches  = 0;
        endfunction

        function bit overlaps_too_much(box_t a, box_t b);
            int x1, y1, x2, y2;
            longint iw, ih, inter, uni;
            x1 = (a.left > b.left) ? a.left : b.left;
            y1 = (a.top > b.top) ? a.top : b.top;
            x2 = (a.left + int'(a.width) < b.left + int'(b.width)) ?
                 a.left + int'(a.width) : b.left + int'(b.width);
            y2 = (a.top + int'(a.height) < b.top + int'(b.height)) ?
                 a.top + int'(a.height) : b.top + int'(b.height);
            iw = (x2 > x1) ? x2 - x1 : 0;
            ih = (y2 > y1) ? y2 - y1 : 0;
            inter = iw * ih;
            uni = longint'(a.width) * a.height + longint'(b.width) * b.height - inter;
            return inter * 65536 > longint'(thresh) * uni;
        endfunction

        function void note_box(box_t bx, logic last);
            int rank[$];
            bit gone[$];
            int n, j, nkept, emitted;
            kept_t k;
            if (set_boxes.size() < MAX_BOXES)
                set_boxes.push_back(bx);
            else
                set_dropped = 1;
            if (!last)
                return;
            n = set_boxes.size();
            // Stable ranking by descending score.
            for (int i = 0; i < n; i++)
            begin
                j = 0;
                while (j < rank.size() && set_boxes[rank[j]].score >= set_boxes[i].score)
                    j++;
                rank.insert(j, i);
                gone.push_back(0);
            end
            // Greedy suppression walk.
            for (int i = 0; i < n; i++)
            begin
                if (gone[i])
                    continue;
                for (int m = i + 1; m < n; m++)
                    if (!gone[m] &&
                        overlaps_too_much(set_boxes[rank[i]], set_boxes[rank[m]]))
                        gone[m] = 1;
            end
            nkept = 0;
            foreach (gone[i])
                if (!gone[i])
                    nkept++;
            emitted = 0;
            for (int i = 0; i < n; i++)
            begin
                if (gone[i])
                    continue;
                emitted++;
                k.idx = 6'(rank[i]);
                k.bx  = set_boxes[rank[i]];
                k.fin = (emitted == nkept);
                k.ovf = set_dropped;
                kept_q.push_back(k);
            end
            set_boxes.delete();
            set_dropped = 0;
        endfunction

        function void check_kept(kept_t got);
            kept_t want;
            if (kept_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d score %0d", got.idx, got.bx.score);
                return;
            end
            want = kept_q.pop_front();
            if (got.idx !== want.idx || got.bx !== want.bx || got.fin !== want.fin ||
                got.ovf !== want.ovf)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp idx %0d box %h fin %b ovf %b,",
                              " got idx %0d box %h fin %b ovf %b"},
                             want.idx, want.bx, want.fin, want.ovf,
                             got.idx, got.bx, got.fin, got.ovf);
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [15:0]        score = 0;
    logic signed [11:0] left = 0;
    logic signed [11:0] top = 0;
    logic [10:0]        width = 0;
    logic [10:0]        height = 0;
    logic               last_box = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = 0;
    logic               result_valid;
    logic [5:0]         box_index;
    logic [15:0]        kept_score;
    logic signed [11:0] kept_left;
    logic signed [11:0] kept_top;
    logic [10:0]        kept_width;
    logic [10:0]        kept_height;
    logic               final_result;
    logic               overflow;

    nms_scoreboard sb = new();
    int cycles = 0;
    int sent = 0;
    bit quiet_stretch = 0;

    class_agnostic_box_nms dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .score(score), .left(left), .top(top), .width(width), .height(height),
        .last_box(last_box), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .result_valid(result_valid), .box_index(box_index),
        .kept_score(kept_score), .kept_left(kept_left), .kept_top(kept_top),
        .kept_width(kept_width), .kept_height(kept_height),
        .final_result(final_result), .overflow(overflow)
    );

    // Clock.
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Cycle count and timeout.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result monitor: every strobe is one kept box.
    always @(posedge clk)
    begin
        kept_t got;
        if (rst_n && result_valid)
        begin
            got.idx = box_index;
            got.bx  = '{kept_score, kept_left, kept_top, kept_width, kept_height};
            got.fin = final_result;
            got.ovf = overflow;
            sb.check_kept(got);
        end
    end

    // Send one box beat, with an optional idle gap ahead of it.
    task automatic send_box(box_t bx, logic last);
        if (!quiet_stretch && $urandom_range(0, 99) < 24)
        begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start    <= 1;
        score    <= bx.score;
        left     <= bx.left;
        top      <= bx.top;
        width    <= bx.width;
        height   <= bx.height;
        last_box <= last;
        do
            @(posedge clk);
        while (busy);
        sb.note_box(bx, last);
        sent++;
    endtask

    // Hold off until every kept box has come and the block has settled.
    task automatic wait_drained();
        start <= 0;
        @(posedge clk);
        while (sb.kept_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Threshold write, only while the block is idle.
    task automatic write_thresh(logic [15:0] v);
        wait_drained();
        cfg_valid <= 1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        sb.thresh = v;
    endtask

    function automatic box_t any_box();
        box_t b;
        b.score  = 16'($urandom);
        b.left   = 12'($urandom);
        b.top    = 12'($urandom);
        b.width  = 11'($urandom);
        b.height = 11'($urandom);
        return b;
    endfunction

    // A set of n boxes, mostly clustered around a few centers so that
    // suppression actually happens, with some fully random noise boxes.
    task automatic send_set(int n);
        box_t base, b;
        logic [15:0] prev_score;
        base = any_box();
        base.left   = 12'($urandom_range(0, 3800) - 2048);
        base.top    = 12'($urandom_range(0, 3800) - 2048);
        base.width  = 11'($urandom_range(1, 120));
        base.height = 11'($urandom_range(1, 120));
        prev_score  = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                b = any_box();
            else
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    base.left = 12'($urandom_range(0, 3800) - 2048);
                    base.top  = 12'($urandom_range(0, 3800) - 2048);
                end
                b.score  = ($urandom_range(0, 3) == 0) ? prev_score : 16'($urandom);
                b.left   = 12'(base.left + $urandom_range(0, 16));
                b.top    = 12'(base.top + $urandom_range(0, 16));
                b.width  = 11'(base.width + $urandom_range(0, 8));
                b.height = 11'(base.height + $urandom_range(0, 8));
            end
            prev_score = b.score;
            send_box(b, i == n - 1);
        end
    endtask

    initial
    begin
        logic [15:0] thr_list[6];
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, equal scores, degenerate boxes, single box set.
        send_box('{16'hFFFF, -12'sd2048, -12'sd2048, 11'd2047, 11'd2047}, 0);
        send_box('{16'h0000, 12'sd2047, 12'sd2047, 11'd0, 11'd0}, 0);
        send_box('{16'hFFFF, -12'sd2048, -12'sd2048, 11'd2047, 11'd2047}, 0);
        send_box('{16'h8000, 12'sd0, 12'sd0, 11'd0, 11'd50}, 0);
        send_box('{16'h0064, 12'sd10, 12'sd10, 11'd10, 11'd10}, 0);
        send_box('{16'h0064, 12'sd10, 12'sd10, 11'd10, 11'd10}, 0);
        send_box('{16'h0064, 12'sd12, 12'sd10, 11'd10, 11'd10}, 0);
        send_box('{16'h7FFF, 12'sd2047, -12'sd2048, 11'd1, 11'd2047}, 1);
        send_box('{16'h1234, 12'sd5, -12'sd5, 11'd3, 11'd4}, 1);
        send_box('{16'h0000, 12'sd0, 12'sd0, 11'd0, 11'd0}, 1);

        thr_list = '{16'd0, 16'hFFFF, 16'd32768, 16'($urandom), 16'd1, 16'd16384};
        foreach (thr_list[p])
        begin
            write_thresh(thr_list[p]);
            if (p == 1)
                send_set(64);
            if (p == 3)
                send_set(66);
            quiet_stretch = (p == 2);
            for (int s = 0; s < 8; s++)
                send_set(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                     : $urandom_range(1, 6));
            quiet_stretch = 0;
        end
        while (sent < 370)
            send_set($urandom_range(1, 6));

        wait_drained();
        if (sb.mismatches == 0 && sb.kept_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
